// ----- hw/rtl/cfp_pkg.sv -----
// Shared types, constants and helpers for the CSV command frame parser.
package cfp_pkg;

  localparam int FIELD_CHARS = 32;
  localparam int POS_W = $clog2(FIELD_CHARS);
  localparam int MAX_PARAMS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FRAC_DIGITS = 9;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0] FALLBACK_RESET = 8'd5;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_FALLBACK = 2'd1;

  typedef enum logic [1:0] {
    FK_COUNT = 2'd0,
    FK_COMMAND = 2'd1,
    FK_PARAM = 2'd2,
    FK_TIMEOUT = 2'd3
  } field_kind_t;

  typedef enum logic [1:0] {
    IK_CHAR = 2'd0,
    IK_DELIM = 2'd1,
    IK_TICK = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_DSET,
    ST_DIV,
    ST_FIN
  } back_state_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC
  } phase_t;

  function automatic logic [29:0] pow10(input logic [3:0] nd);
    logic [29:0] r;
    case (nd)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/cfp_front.sv -----
// Front end: classify incoming items and queue them for the back end.
module cfp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             cmd,
  input  logic [7:0]       rx_byte,
  output cfp_pkg::item_t   item,
  output logic             item_valid,
  input  logic             item_pop
);

  localparam int PTR_W = $clog2(cfp_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(cfp_pkg::FIFO_DEPTH + 1);

  cfp_pkg::item_t slots [cfp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;
  cfp_pkg::item_t incoming;

  assign full = count == CNT_W'(cfp_pkg::FIFO_DEPTH);
  assign item_valid = count != '0;
  assign item = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = item_pop && item_valid;

  always_comb begin
    incoming.data = rx_byte;
    if (cmd) begin
      incoming.kind = cfp_pkg::IK_TICK;
    end else if (rx_byte == cfp_pkg::CH_COMMA || rx_byte == cfp_pkg::CH_NEWLINE) begin
      incoming.kind = cfp_pkg::IK_DELIM;
    end else begin
      incoming.kind = cfp_pkg::IK_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/cfp_back.sv -----
// Back end: field buffer, conversion walk, divider, message state and result register.
module cfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          timeout_ticks,
  input  logic [7:0]           fallback_command,
  input  cfp_pkg::item_t       item,
  input  logic                 item_valid,
  output logic                 item_pop,
  output logic                 out_valid,
  input  logic                 out_pop,
  output logic [1:0]           field_kind,
  output logic [3:0]           param_index,
  output logic signed [47:0]   field_value,
  output logic signed [31:0]   command_id,
  output logic signed [31:0]   param_count,
  output logic                 command_ready
);

  localparam int POS_W = cfp_pkg::POS_W;

  cfp_pkg::back_state_t state, state_next;
  cfp_pkg::phase_t phase;
  cfp_pkg::field_kind_t o_kind;

  logic [7:0] chars [cfp_pkg::FIELD_CHARS];
  logic [7:0] rdata;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] walk_p;
  logic [POS_W-1:0] walk_len;
  logic [4:0] field_number;
  logic signed [31:0] expected;
  logic signed [31:0] held;
  logic open;
  logic [15:0] elapsed;
  logic is_fixed;
  logic neg;
  logic [32:0] ipart;
  logic [29:0] fnum;
  logic [3:0] nd;
  logic [46:0] div_rem;
  logic [46:0] div_d;
  logic [16:0] quo;
  logic [4:0] div_cnt;

  logic c_blank, c_digit, c_sign, c_point, cont, more;
  logic [36:0] ip_tmp, ip_lim;
  logic [32:0] ip_new;
  logic [32:0] fn_tmp;
  logic [15:0] el_new;
  logic [31:0] ival;
  logic [49:0] mag;
  logic [47:0] fval;
  logic [4:0] fn_inc;
  logic [4:0] pidx;
  logic signed [31:0] exp_new, held_new;
  logic signed [32:0] fn_m2;
  logic done;
  logic [29:0] den;

  function automatic logic is_fixed_sel();
    return field_number >= 5'd2;
  endfunction

  assign field_kind = o_kind;
  assign item_pop = state == cfp_pkg::ST_IDLE && item_valid && !out_valid;

  always_comb begin
    c_blank = rdata == cfp_pkg::CH_SPACE || (rdata >= 8'h09 && rdata <= 8'h0D);
    c_digit = rdata >= 8'h30 && rdata <= 8'h39;
    c_sign = rdata == cfp_pkg::CH_PLUS || rdata == cfp_pkg::CH_MINUS;
    c_point = rdata == cfp_pkg::CH_POINT && is_fixed;
    ip_tmp = {1'b0, ipart, 3'b0} + {3'b0, ipart, 1'b0} + {33'b0, rdata[3:0]};
    ip_lim = is_fixed ? 37'h1_0000_0000 : 37'h0_8000_0000;
    ip_new = (ip_tmp > ip_lim) ? ip_lim[32:0] : ip_tmp[32:0];
    fn_tmp = {fnum, 3'b0} + {2'b0, fnum, 1'b0} + {29'b0, rdata[3:0]};
    unique case (phase)
      cfp_pkg::PH_LEAD: cont = c_blank || c_sign || c_digit || c_point;
      cfp_pkg::PH_INT: cont = c_digit || c_point;
      cfp_pkg::PH_FRAC: cont = c_digit;
      default: cont = 1'b0;
    endcase
    more = cont && ({1'b0, walk_p} + 1'b1 < {1'b0, walk_len});

    el_new = (elapsed == 16'hFFFF) ? elapsed : elapsed + 1'b1;

    ival = neg ? (~ipart[31:0] + 1'b1)
               : ((ipart > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : ipart[31:0]);
    mag = {1'b0, ipart, 16'b0} + {33'b0, quo};
    if (neg) begin
      fval = (mag > 50'h0_8000_0000_0000) ? 48'h8000_0000_0000 : (~mag[47:0] + 1'b1);
    end else begin
      fval = (mag > 50'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
    end

    exp_new = (field_number == 5'd0) ? $signed(ival) : expected;
    held_new = (field_number == 5'd1) ? $signed(ival) : held;
    fn_inc = field_number + 1'b1;
    fn_m2 = $signed({28'b0, fn_inc}) - 33'sd2;
    done = fn_m2 == {exp_new[31], exp_new};
    pidx = (field_number - 5'd2 > 5'(cfp_pkg::MAX_PARAMS - 1))
           ? 5'(cfp_pkg::MAX_PARAMS - 1) : field_number - 5'd2;
    den = cfp_pkg::pow10(nd);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cfp_pkg::ST_IDLE: begin
        if (item_pop && item.kind == cfp_pkg::IK_DELIM) begin
          state_next = (pos == '0) ? (is_fixed_sel() ? cfp_pkg::ST_DSET : cfp_pkg::ST_FIN)
                                   : cfp_pkg::ST_FETCH;
        end
      end
      cfp_pkg::ST_FETCH: state_next = cfp_pkg::ST_EVAL;
      cfp_pkg::ST_EVAL: begin
        if (more) begin
          state_next = cfp_pkg::ST_FETCH;
        end else begin
          state_next = is_fixed ? cfp_pkg::ST_DSET : cfp_pkg::ST_FIN;
        end
      end
      cfp_pkg::ST_DSET: state_next = cfp_pkg::ST_DIV;
      cfp_pkg::ST_DIV: begin
        if (div_cnt == 5'd16) begin
          state_next = cfp_pkg::ST_FIN;
        end
      end
      cfp_pkg::ST_FIN: state_next = cfp_pkg::ST_IDLE;
      default: state_next = cfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cfp_pkg::ST_IDLE && item_pop && item.kind == cfp_pkg::IK_CHAR) begin
      chars[pos] <= item.data;
    end
    rdata <= chars[walk_p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      field_number <= '0;
      expected <= '0;
      held <= '0;
      open <= 1'b0;
      elapsed <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        cfp_pkg::ST_IDLE: begin
          if (item_pop) begin
            unique case (item.kind)
              cfp_pkg::IK_CHAR: begin
                if (pos != POS_W'(cfp_pkg::FIELD_CHARS - 1)) begin
                  pos <= pos + 1'b1;
                end
              end
              cfp_pkg::IK_DELIM: begin
                walk_len <= pos;
                walk_p <= '0;
                pos <= '0;
                is_fixed <= is_fixed_sel();
                neg <= 1'b0;
                phase <= cfp_pkg::PH_LEAD;
                ipart <= '0;
                fnum <= '0;
                nd <= '0;
              end
              default: begin
                if (open) begin
                  elapsed <= el_new;
                  if (el_new > timeout_ticks) begin
                    held <= {24'b0, fallback_command};
                    expected <= '0;
                    field_number <= '0;
                    open <= 1'b0;
                    o_kind <= cfp_pkg::FK_TIMEOUT;
                    param_index <= '0;
                    field_value <= '0;
                    command_id <= {24'b0, fallback_command};
                    param_count <= '0;
                    command_ready <= 1'b1;
                    out_valid <= 1'b1;
                  end
                end
              end
            endcase
          end
        end
        cfp_pkg::ST_EVAL: begin
          if (more) begin
            walk_p <= walk_p + 1'b1;
          end
          unique case (phase)
            cfp_pkg::PH_LEAD: begin
              if (c_sign) begin
                neg <= rdata == cfp_pkg::CH_MINUS;
                phase <= cfp_pkg::PH_INT;
              end else if (c_digit) begin
                ipart <= ip_new;
                phase <= cfp_pkg::PH_INT;
              end else if (c_point) begin
                phase <= cfp_pkg::PH_FRAC;
              end
            end
            cfp_pkg::PH_INT: begin
              if (c_digit) begin
                ipart <= ip_new;
              end else if (c_point) begin
                phase <= cfp_pkg::PH_FRAC;
              end
            end
            default: begin
              if (c_digit && nd < 4'(cfp_pkg::FRAC_DIGITS)) begin
                fnum <= fn_tmp[29:0];
                nd <= nd + 1'b1;
              end
            end
          endcase
        end
        cfp_pkg::ST_DSET: begin
          div_rem <= {1'b0, fnum, 16'b0} + {17'b0, 1'b0, den[29:1]};
          div_d <= {1'b0, den, 16'b0};
          quo <= '0;
          div_cnt <= '0;
        end
        cfp_pkg::ST_DIV: begin
          if (div_rem >= div_d) begin
            div_rem <= div_rem - div_d;
            quo <= {quo[15:0], 1'b1};
          end else begin
            quo <= {quo[15:0], 1'b0};
          end
          div_d <= {1'b0, div_d[46:1]};
          div_cnt <= div_cnt + 1'b1;
        end
        cfp_pkg::ST_FIN: begin
          expected <= exp_new;
          held <= held_new;
          if (field_number == 5'd0) begin
            if (!done) begin
              open <= 1'b1;
            end
            elapsed <= '0;
            o_kind <= cfp_pkg::FK_COUNT;
          end else if (field_number == 5'd1) begin
            o_kind <= cfp_pkg::FK_COMMAND;
          end else begin
            o_kind <= cfp_pkg::FK_PARAM;
          end
          param_index <= is_fixed ? pidx[3:0] : 4'd0;
          field_value <= is_fixed ? fval : {{16{ival[31]}}, ival};
          command_id <= held_new;
          param_count <= exp_new;
          if (done) begin
            field_number <= '0;
            open <= 1'b0;
            command_ready <= 1'b1;
          end else begin
            field_number <= fn_inc;
            command_ready <= 1'b0;
          end
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pop |=> out_valid && $stable(field_value))
    else $error("result changed while waiting");

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    state == cfp_pkg::ST_FIN |-> !out_valid)
    else $error("result register busy at field end");

  a_timeout: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_kind == cfp_pkg::FK_TIMEOUT |-> command_ready && param_count == 0)
    else $error("timeout result malformed");

  a_walk: assert property (@(posedge clk) disable iff (rst)
    state == cfp_pkg::ST_FETCH |-> walk_p < walk_len)
    else $error("walk beyond field");

endmodule

// ----- hw/rtl/csv_command_frame_parser.sv -----
// Top level of the CSV command frame parser: configuration registers and the two halves.
// Bytes and ticks are queued (four items) and handled one at a time. A comma or newline
// walks the buffered field character by character, fetch then evaluate, over the single
// buffer read port, then a parameter field runs a restoring divider for the rounded
// fraction. Config writes are accepted every cycle (cfg_ready is always high).
module csv_command_frame_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 cmd,
  input  logic [7:0]           rx_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           field_kind,
  output logic [3:0]           param_index,
  output logic signed [47:0]   field_value,
  output logic signed [31:0]   command_id,
  output logic signed [31:0]   param_count,
  output logic                 command_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] timeout_ticks;
  logic [7:0] fallback_command;
  cfp_pkg::item_t item;
  logic item_valid;
  logic item_pop;
  logic out_valid;

  assign cfg_ready = 1'b1;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= cfp_pkg::TIMEOUT_RESET;
      fallback_command <= cfp_pkg::FALLBACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfp_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        cfp_pkg::CFG_FALLBACK: fallback_command <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  cfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  cfp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .timeout_ticks    (timeout_ticks),
    .fallback_command (fallback_command),
    .item             (item),
    .item_valid       (item_valid),
    .item_pop         (item_pop),
    .out_valid        (out_valid),
    .out_pop          (pop),
    .field_kind       (field_kind),
    .param_index      (param_index),
    .field_value      (field_value),
    .command_id       (command_id),
    .param_count      (param_count),
    .command_ready    (command_ready)
  );

endmodule

// ----- test/csv_command_frame_parser_chk.sv -----
// Checker for the CSV command frame parser: tracks accepted items, predicts results, compares.
module csv_command_frame_parser_chk (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  logic                cmd,
  input  logic [7:0]          rx_byte,
  input  logic                empty,
  input  logic                pop,
  input  logic [1:0]          field_kind,
  input  logic [3:0]          param_index,
  input  logic signed [47:0]  field_value,
  input  logic signed [31:0]  command_id,
  input  logic signed [31:0]  param_count,
  input  logic                command_ready,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cfp_pkg::field_kind_t kind;
    logic [3:0]   idx;
    logic [47:0]  value;
    logic [31:0]  cmd_id;
    logic [31:0]  count;
    logic         ready;
  } field_result_t;

  localparam logic [63:0] Q_MAX = 64'd140737488355327;

  field_result_t result_q[$];
  logic [7:0]    chars[cfp_pkg::FIELD_CHARS];
  int unsigned   pos;
  int unsigned   field_no;
  logic [31:0]   want_params;
  logic [31:0]   cmd_hold;
  logic          msg_open;
  logic [15:0]   ticks;
  logic [15:0]   timeout_ticks;
  logic [7:0]    fallback_cmd;

  function automatic bit is_blank(logic [7:0] c);
    return c == cfp_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic int unsigned skip_lead(int unsigned len, output bit neg);
    int unsigned p;
    p = 0;
    neg = 0;
    while (p < len && chars[p] != 8'h00 && is_blank(chars[p])) p++;
    if (p < len && (chars[p] == cfp_pkg::CH_PLUS || chars[p] == cfp_pkg::CH_MINUS)) begin
      neg = chars[p] == cfp_pkg::CH_MINUS;
      p++;
    end
    return p;
  endfunction

  function automatic logic [63:0] parse_int(int unsigned len);
    bit neg;
    int unsigned p;
    logic [63:0] mag;
    p = skip_lead(len, neg);
    mag = 0;
    while (p < len && is_num(chars[p])) begin
      mag = mag * 10 + 64'(chars[p] - 8'h30);
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      p++;
    end
    if (neg) return -mag;
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag;
  endfunction

  function automatic logic [63:0] parse_q16(int unsigned len);
    bit neg;
    int unsigned p, nd;
    logic [63:0] ipart, fnum, fden, mag;
    p = skip_lead(len, neg);
    ipart = 0;
    fnum = 0;
    fden = 1;
    nd = 0;
    while (p < len && is_num(chars[p])) begin
      ipart = ipart * 10 + 64'(chars[p] - 8'h30);
      if (ipart > 64'h1_0000_0000) ipart = 64'h1_0000_0000;
      p++;
    end
    if (p < len && chars[p] == cfp_pkg::CH_POINT) begin
      p++;
      while (p < len && is_num(chars[p])) begin
        if (nd < cfp_pkg::FRAC_DIGITS) begin
          fnum = fnum * 10 + 64'(chars[p] - 8'h30);
          fden = fden * 10;
          nd++;
        end
        p++;
      end
    end
    mag = (ipart << 16) + (fnum * 65536 + fden / 2) / fden;
    if (neg) begin
      if (mag > Q_MAX + 1) mag = Q_MAX + 1;
      return -mag;
    end
    if (mag > Q_MAX) mag = Q_MAX;
    return mag;
  endfunction

  task automatic add_result(cfp_pkg::field_kind_t k, logic [3:0] i, logic [63:0] v, logic r);
    field_result_t e;
    e.kind = k;
    e.idx = i;
    e.value = v[47:0];
    e.cmd_id = cmd_hold;
    e.count = want_params;
    e.ready = r;
    result_q.push_back(e);
  endtask

  task automatic parse_item(logic is_tick, logic [7:0] c);
    int unsigned len, idx;
    logic [63:0] v;
    cfp_pkg::field_kind_t k;
    logic r;
    if (is_tick) begin
      if (!msg_open) return;
      if (ticks < 16'hFFFF) ticks++;
      if (ticks <= timeout_ticks) return;
      cmd_hold = 32'(fallback_cmd);
      want_params = 0;
      field_no = 0;
      msg_open = 0;
      add_result(cfp_pkg::FK_TIMEOUT, 4'd0, 64'd0, 1'b1);
      return;
    end
    if (c != cfp_pkg::CH_COMMA && c != cfp_pkg::CH_NEWLINE) begin
      chars[pos] = c;
      pos++;
      if (pos >= cfp_pkg::FIELD_CHARS) pos = cfp_pkg::FIELD_CHARS - 1;
      return;
    end
    len = pos;
    pos = 0;
    idx = 0;
    r = 0;
    if (field_no == 0) begin
      v = parse_int(len);
      want_params = v[31:0];
      msg_open = 1;
      ticks = 0;
      k = cfp_pkg::FK_COUNT;
    end else if (field_no == 1) begin
      v = parse_int(len);
      cmd_hold = v[31:0];
      k = cfp_pkg::FK_COMMAND;
    end else begin
      v = parse_q16(len);
      idx = field_no - 2;
      if (idx > cfp_pkg::MAX_PARAMS - 1) idx = cfp_pkg::MAX_PARAMS - 1;
      k = cfp_pkg::FK_PARAM;
    end
    field_no = (field_no + 1) % 32;
    if (longint'(field_no) - 2 == longint'(signed'(want_params))) begin
      field_no = 0;
      msg_open = 0;
      r = 1;
    end
    add_result(k, 4'(idx), v, r);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    fail_count++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
  endtask

  always @(posedge clk) begin
    field_result_t e;
    if (rst) begin
      result_q.delete();
      fail_count = 0;
      pos = 0;
      field_no = 0;
      want_params = 0;
      cmd_hold = 0;
      msg_open = 0;
      ticks = 0;
      timeout_ticks = cfp_pkg::TIMEOUT_RESET;
      fallback_cmd = cfp_pkg::FALLBACK_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cfp_pkg::CFG_TIMEOUT) timeout_ticks = cfg_data;
        else if (cfg_index == cfp_pkg::CFG_FALLBACK) fallback_cmd = cfg_data[7:0];
      end
      if (push && !full) parse_item(cmd, rx_byte);
      if (pop && !empty) begin
        if (result_q.size() == 0) begin
          report("unexpected item", 64'(field_kind), 64'd0);
        end else begin
          e = result_q.pop_front();
          if (field_kind != e.kind) report("field_kind", 64'(field_kind), 64'(e.kind));
          if (param_index != e.idx) report("param_index", 64'(param_index), 64'(e.idx));
          if (field_value != e.value) report("field_value", 64'(field_value), 64'(e.value));
          if (command_id != e.cmd_id) report("command_id", 64'(command_id), 64'(e.cmd_id));
          if (param_count != e.count) report("param_count", 64'(param_count), 64'(e.count));
          if (command_ready != e.ready)
            report("command_ready", 64'(command_ready), 64'(e.ready));
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ----- test/csv_command_frame_parser_tb.sv -----
// Testbench top for the CSV command frame parser: clock, reset, stimulus and verdict.
module csv_command_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 100;

  logic               clk, rst;
  logic               push, full, cmd, empty, pop;
  logic [7:0]         rx_byte;
  logic [1:0]         field_kind;
  logic [3:0]         param_index;
  logic signed [47:0] field_value;
  logic signed [31:0] command_id, param_count;
  logic               command_ready;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count, pending;
  int                 items_sent;
  int                 idle_cycles;
  bit                 no_gaps;
  bit                 hold_req;
  bit                 hold_done;

  csv_command_frame_parser u_dut (.*);

  csv_command_frame_parser_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic c, logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      push = 0;
      repeat (g) @(negedge clk);
    end
    push = 1;
    cmd = c;
    rx_byte = b;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 0;
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_digits(int n);
    for (int i = 0; i < n; i++) send_item(1'b0, 8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_number(bit fixed);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) send_item(1'b0, cfp_pkg::CH_SPACE);
    r = $urandom_range(0, 3);
    if (r == 0) send_item(1'b0, cfp_pkg::CH_MINUS);
    else if (r == 1) send_item(1'b0, cfp_pkg::CH_PLUS);
    r = $urandom_range(0, 9);
    send_digits(r < 8 ? $urandom_range(0, 4) : $urandom_range(5, 14));
    if (fixed && $urandom_range(0, 2) != 0) begin
      send_item(1'b0, cfp_pkg::CH_POINT);
      send_digits($urandom_range(0, 12));
    end
    if ($urandom_range(0, 19) == 0) send_item(1'b0, 8'($urandom));
  endtask

  task automatic maybe_tick();
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 6)) send_tick();
  endtask

  task automatic send_message();
    int n, r;
    r = $urandom_range(0, 19);
    if (r == 0) n = -1;
    else if (r == 1) n = $urandom_range(15, 20);
    else n = $urandom_range(0, 4);
    if ($urandom_range(0, 15) == 0) send_number(1'b0);
    else send_text($sformatf("%0d", n));
    send_item(1'b0, cfp_pkg::CH_COMMA);
    maybe_tick();
    if (n == -1) return;
    send_number(1'b0);
    send_item(1'b0, cfp_pkg::CH_COMMA);
    for (int i = 0; i < n; i++) begin
      maybe_tick();
      send_number(1'b1);
      send_item(1'b0, ($urandom_range(0, 1) != 0) ? cfp_pkg::CH_COMMA : cfp_pkg::CH_NEWLINE);
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 40)) send_tick();
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) send_tick();
          else send_item(1'b0, 8'($urandom));
        end
      end else begin
        send_message();
      end
    end
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int stall;
    pop = 0;
    stall = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        pop = 0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end else if (stall > 0) begin
        pop = 0;
        stall--;
      end else begin
        pop = 1;
        stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1;
    push = 0;
    cmd = 0;
    rx_byte = 0;
    cfg_valid = 0;
    cfg_index = cfp_pkg::CFG_TIMEOUT;
    cfg_data = 0;
    items_sent = 0;
    no_gaps = 0;
    hold_req = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    send_text("2,17,-3.5,0.00001\n");
    send_text("-1,");
    send_text(" +99999999999,-99999999999,");
    send_item(1'b0, 8'h00);
    send_text("7\n");
    send_text("1,4,-4294967296.99999,1,4294967297.5e3,");
    send_text("0,123456789012345678901234567890123456789\n");
    settle();

    write_reg(cfp_pkg::CFG_TIMEOUT, 16'd0);
    write_reg(cfp_pkg::CFG_FALLBACK, 16'd0);
    send_text("3,");
    send_tick();
    send_text("2,9,.5,");
    send_tick();
    run_phase(300);
    settle();

    write_reg(cfp_pkg::CFG_TIMEOUT, 16'hFFFF);
    write_reg(cfp_pkg::CFG_FALLBACK, 16'hFFFF);
    hold_req = 1;
    no_gaps = 1;
    run_phase(350);
    no_gaps = 0;
    settle();

    write_reg(cfp_pkg::CFG_TIMEOUT, 16'd5);
    write_reg(cfp_pkg::CFG_FALLBACK, 16'd200);
    run_phase(350);
    settle();

    write_reg(cfp_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 30)));
    write_reg(cfp_pkg::CFG_FALLBACK, 16'($urandom_range(0, 255)));
    run_phase(350);
    settle();

    write_reg(cfp_pkg::CFG_TIMEOUT, 16'd1000);
    write_reg(cfp_pkg::CFG_FALLBACK, 16'd5);
    run_phase(400);
    settle();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_back.sv
hw/rtl/csv_command_frame_parser.sv
test/csv_command_frame_parser_chk.sv
test/csv_command_frame_parser_tb.sv
